@@ hdl/sclc_pkg.sv @@
package sclc_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int SLOT_W = 6;
    localparam int MAX_RES = 64;
    localparam int RCNT_W = $clog2(MAX_RES + 1);
    localparam int PIN_W = 8;
    localparam logic [PIN_W-1:0] PIN_MAX = '1;

    typedef enum logic [1:0] {
        CMD_GET   = 2'd0,
        CMD_REL   = 2'd1,
        CMD_PROBE = 2'd2,
        CMD_SWEEP = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_VICTIM   = 2'd1,
        ST_BAD_RELEASE = 2'd2,
        ST_PIN_OVF     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_SWEEP,
        S_EMPTY
    } t_state;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] sector;
        logic        wr;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              fetch_needed;
        logic              evicted;
        logic [31:0]       victim_sector;
        logic              victim_dirty;
        logic [31:0]       sweep_sector;
        logic              sweep_valid;
        logic              last;
        logic [1:0]        status;
    } t_res;

    typedef struct packed {
        logic [31:0]      tag;
        logic [31:0]      stamp;
        logic [PIN_W-1:0] pins;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] ext;
        ext = {{SLOT_W{1'b0}}, idx};
        return ext[SLOT_W-1:0];
    endfunction

endpackage

@@ hdl/sector_cache_lru_controller_core.sv @@
// Channel   Direction  Handshake          Payload
// request   in         i_valid / o_stall  i_cmd, i_sector, i_write_flag
// result    out        o_valid / i_stall  o_hit .. o_status
//
// Get, release and probe scan all entries of the tag memory, one per cycle; a sweep
// scans the same way, ending after the last dirty entry, and is held while the
// result side stalls.
// A two-deep request queue decouples input.
// Reset is synchronous and clears valid, dirty and the access counter at once.

module sector_cache_lru_controller_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_sector,
    input  logic        i_write_flag,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_hit,
    output logic [5:0]  o_slot,
    output logic        o_fetch_needed,
    output logic        o_evicted,
    output logic [31:0] o_victim_sector,
    output logic        o_victim_dirty,
    output logic [31:0] o_sweep_sector,
    output logic        o_sweep_valid,
    output logic        o_last,
    output logic [1:0]  o_status
);

    logic           req_valid;
    logic           req_pop;
    sclc_pkg::t_req req;
    sclc_pkg::t_res res;

    sclc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_sector    (i_sector),
        .i_write_flag(i_write_flag),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_req_pop   (req_pop)
    );

    sclc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(req_valid),
        .i_req      (req),
        .o_req_pop  (req_pop),
        .i_out_stall(i_stall),
        .o_out_valid(o_valid),
        .o_res      (res)
    );

    assign o_hit           = res.hit;
    assign o_slot          = res.slot;
    assign o_fetch_needed  = res.fetch_needed;
    assign o_evicted       = res.evicted;
    assign o_victim_sector = res.victim_sector;
    assign o_victim_dirty  = res.victim_dirty;
    assign o_sweep_sector  = res.sweep_sector;
    assign o_sweep_valid   = res.sweep_valid;
    assign o_last          = res.last;
    assign o_status        = res.status;

endmodule

@@ hdl/sclc_ram.sv @@
module sclc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ hdl/sclc_front.sv @@
module sclc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_cmd,
    input  logic [31:0]       i_sector,
    input  logic              i_write_flag,
    output logic              o_req_valid,
    output sclc_pkg::t_req    o_req,
    input  logic              i_req_pop
);

    sclc_pkg::t_req r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    logic           pop;
    sclc_pkg::t_req req_in;

    always_comb begin
        req_in.cmd    = sclc_pkg::t_cmd'(i_cmd);
        req_in.sector = i_sector;
        req_in.wr     = i_write_flag && (req_in.cmd == sclc_pkg::CMD_GET);
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign push        = i_valid && !o_stall;
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];
    assign pop         = i_req_pop && o_req_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            r_q[r_wp] <= req_in;
        end
    end

endmodule

@@ hdl/sclc_back.sv @@
module sclc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  sclc_pkg::t_req i_req,
    output logic           o_req_pop,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output sclc_pkg::t_res o_res
);

    localparam int IW = sclc_pkg::IDX_W;
    localparam logic [IW:0] PTR_END = (IW + 1)'(sclc_pkg::ENTRIES);
    localparam logic [sclc_pkg::RCNT_W-1:0] CNT_LAST =
        sclc_pkg::RCNT_W'(sclc_pkg::MAX_RES - 1);

    sclc_pkg::t_state r_state, n_state;
    sclc_pkg::t_req   r_req, n_req;

    logic [IW:0]   r_ptr, n_ptr;
    logic          r_dv, n_dv;
    logic [IW-1:0] r_didx, n_didx;

    logic [sclc_pkg::ENTRIES-1:0] r_valid, n_valid, r_dirty, n_dirty;

    logic                      r_found, n_found;
    logic [IW-1:0]             r_fidx, n_fidx;
    logic [sclc_pkg::PIN_W-1:0] r_fpins, n_fpins;
    logic [31:0]               r_fstamp, n_fstamp;
    logic                      r_inv, n_inv;
    logic [IW-1:0]             r_iidx, n_iidx;
    logic                      r_vic, n_vic;
    logic [IW-1:0]             r_vidx, n_vidx;
    logic [31:0]               r_vtag, n_vtag;
    logic [31:0]               r_vage, n_vage;

    logic [sclc_pkg::RCNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]                 r_counter, n_counter;

    logic           r_out_valid, n_out_valid;
    sclc_pkg::t_res r_res, n_res;

    logic                     ram_we;
    logic [IW-1:0]            ram_waddr, ram_raddr;
    sclc_pkg::t_entry         ram_wd, ram_rd;
    logic [sclc_pkg::ENTRY_W-1:0] ram_rbits;

    logic                         out_free;
    logic                         emit_last;
    logic                         sweep_done;
    logic                         stall_eval;
    logic                         d_hit;
    logic [31:0]                  age;
    logic [sclc_pkg::ENTRIES-1:0] later;

    sclc_ram #(
        .WIDTH(sclc_pkg::ENTRY_W),
        .DEPTH(sclc_pkg::ENTRIES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wd),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rbits)
    );

    assign ram_rd      = sclc_pkg::t_entry'(ram_rbits);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;
    assign age         = r_counter - ram_rd.stamp;
    assign d_hit       = r_dv && r_valid[r_didx] && r_dirty[r_didx];

    always_comb begin
        for (int j = 0; j < sclc_pkg::ENTRIES; j++) begin
            later[j] = r_valid[j] && r_dirty[j] && (IW'(j) > r_didx);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sclc_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    if (i_req.cmd != sclc_pkg::CMD_SWEEP) begin
                        n_state = sclc_pkg::S_SCAN;
                    end else if (|(r_valid & r_dirty)) begin
                        n_state = sclc_pkg::S_SWEEP;
                    end else begin
                        n_state = sclc_pkg::S_EMPTY;
                    end
                end
            end
            sclc_pkg::S_SCAN: begin
                if (r_ptr == PTR_END) begin
                    n_state = sclc_pkg::S_FINISH;
                end
            end
            sclc_pkg::S_SWEEP: begin
                if (sweep_done) begin
                    n_state = sclc_pkg::S_IDLE;
                end
            end
            sclc_pkg::S_EMPTY, sclc_pkg::S_FINISH: begin
                if (out_free) begin
                    n_state = sclc_pkg::S_IDLE;
                end
            end
            default: n_state = sclc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_req       = r_req;
        n_ptr       = r_ptr;
        n_dv        = r_dv;
        n_didx      = r_didx;
        n_valid     = r_valid;
        n_dirty     = r_dirty;
        n_found     = r_found;
        n_fidx      = r_fidx;
        n_fpins     = r_fpins;
        n_fstamp    = r_fstamp;
        n_inv       = r_inv;
        n_iidx      = r_iidx;
        n_vic       = r_vic;
        n_vidx      = r_vidx;
        n_vtag      = r_vtag;
        n_vage      = r_vage;
        n_cnt       = r_cnt;
        n_counter   = r_counter;
        n_out_valid = r_out_valid && i_out_stall;
        n_res       = r_res;
        ram_we      = 1'b0;
        ram_waddr   = r_fidx;
        ram_wd      = '0;
        ram_raddr   = r_ptr[IW-1:0];
        o_req_pop   = 1'b0;
        stall_eval  = 1'b0;
        emit_last   = 1'b0;
        sweep_done  = 1'b0;

        unique case (r_state)
            sclc_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    o_req_pop = 1'b1;
                    n_req     = i_req;
                    n_ptr     = '0;
                    n_dv      = 1'b0;
                    n_found   = 1'b0;
                    n_inv     = 1'b0;
                    n_vic     = 1'b0;
                    n_cnt     = '0;
                end
            end
            sclc_pkg::S_SCAN: begin
                n_ptr  = r_ptr + 1'b1;
                n_dv   = (r_ptr != PTR_END);
                n_didx = r_ptr[IW-1:0];
                if (r_dv) begin
                    if (r_valid[r_didx] && ram_rd.tag == r_req.sector && !r_found) begin
                        n_found  = 1'b1;
                        n_fidx   = r_didx;
                        n_fpins  = ram_rd.pins;
                        n_fstamp = ram_rd.stamp;
                    end
                    if (!r_valid[r_didx] && !r_inv) begin
                        n_inv  = 1'b1;
                        n_iidx = r_didx;
                    end
                    if (r_valid[r_didx] && ram_rd.pins == '0 && (!r_vic || age > r_vage)) begin
                        n_vic  = 1'b1;
                        n_vidx = r_didx;
                        n_vtag = ram_rd.tag;
                        n_vage = age;
                    end
                end
            end
            sclc_pkg::S_SWEEP: begin
                if (d_hit && !out_free) begin
                    stall_eval = 1'b1;
                    ram_raddr  = r_didx;
                    n_dv       = 1'b1;
                end else begin
                    n_ptr  = r_ptr + 1'b1;
                    n_dv   = (r_ptr != PTR_END);
                    n_didx = r_ptr[IW-1:0];
                    if (d_hit) begin
                        emit_last          = (r_cnt == CNT_LAST) || !(|later);
                        n_out_valid        = 1'b1;
                        n_res              = '0;
                        n_res.slot         = sclc_pkg::to_slot(r_didx);
                        n_res.sweep_sector = ram_rd.tag;
                        n_res.sweep_valid  = 1'b1;
                        n_res.last         = emit_last;
                        n_cnt              = r_cnt + 1'b1;
                        if (ram_rd.pins == '0) begin
                            n_dirty[r_didx] = 1'b0;
                        end
                    end
                end
                sweep_done = emit_last || (r_ptr == PTR_END && !stall_eval);
            end
            sclc_pkg::S_EMPTY: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_res       = '0;
                    n_res.last  = 1'b1;
                end
            end
            sclc_pkg::S_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_res       = '0;
                    n_res.last  = 1'b1;
                    unique case (r_req.cmd)
                        sclc_pkg::CMD_GET: begin
                            n_counter = r_counter + 1'b1;
                            if (r_found) begin
                                n_res.hit  = 1'b1;
                                n_res.slot = sclc_pkg::to_slot(r_fidx);
                                ram_we     = 1'b1;
                                ram_waddr  = r_fidx;
                                ram_wd.tag   = r_req.sector;
                                ram_wd.stamp = r_counter;
                                if (r_fpins == sclc_pkg::PIN_MAX) begin
                                    n_res.status = sclc_pkg::ST_PIN_OVF;
                                    ram_wd.pins  = r_fpins;
                                end else begin
                                    ram_wd.pins  = r_fpins + 1'b1;
                                end
                                if (r_req.wr) begin
                                    n_dirty[r_fidx] = 1'b1;
                                end
                            end else if (r_inv || r_vic) begin
                                ram_waddr = r_inv ? r_iidx : r_vidx;
                                if (!r_inv) begin
                                    n_res.evicted       = 1'b1;
                                    n_res.victim_sector = r_vtag;
                                    n_res.victim_dirty  = r_dirty[r_vidx];
                                end
                                ram_we               = 1'b1;
                                ram_wd.tag           = r_req.sector;
                                ram_wd.stamp         = r_counter;
                                ram_wd.pins          = sclc_pkg::PIN_W'(1);
                                n_valid[ram_waddr]   = 1'b1;
                                n_dirty[ram_waddr]   = r_req.wr;
                                n_res.slot           = sclc_pkg::to_slot(ram_waddr);
                                n_res.fetch_needed   = 1'b1;
                            end else begin
                                n_res.status = sclc_pkg::ST_NO_VICTIM;
                            end
                        end
                        sclc_pkg::CMD_REL: begin
                            if (r_found) begin
                                n_res.hit  = 1'b1;
                                n_res.slot = sclc_pkg::to_slot(r_fidx);
                            end
                            if (!r_found || r_fpins == '0) begin
                                n_res.status = sclc_pkg::ST_BAD_RELEASE;
                            end else begin
                                ram_we       = 1'b1;
                                ram_waddr    = r_fidx;
                                ram_wd.tag   = r_req.sector;
                                ram_wd.stamp = r_fstamp;
                                ram_wd.pins  = r_fpins - 1'b1;
                            end
                        end
                        sclc_pkg::CMD_PROBE, sclc_pkg::CMD_SWEEP: begin
                            if (r_found) begin
                                n_res.hit       = 1'b1;
                                n_res.slot      = sclc_pkg::to_slot(r_fidx);
                                n_dirty[r_fidx] = 1'b0;
                            end
                        end
                        default: n_res.status = sclc_pkg::ST_OK;
                    endcase
                end
            end
            default: n_out_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sclc_pkg::S_IDLE;
            r_valid     <= '0;
            r_dirty     <= '0;
            r_counter   <= '0;
            r_out_valid <= 1'b0;
            r_dv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_dirty     <= n_dirty;
            r_counter   <= n_counter;
            r_out_valid <= n_out_valid;
            r_dv        <= n_dv;
        end
        r_req    <= n_req;
        r_ptr    <= n_ptr;
        r_didx   <= n_didx;
        r_found  <= n_found;
        r_fidx   <= n_fidx;
        r_fpins  <= n_fpins;
        r_fstamp <= n_fstamp;
        r_inv    <= n_inv;
        r_iidx   <= n_iidx;
        r_vic    <= n_vic;
        r_vidx   <= n_vidx;
        r_vtag   <= n_vtag;
        r_vage   <= n_vage;
        r_cnt    <= n_cnt;
        r_res    <= n_res;
    end

endmodule
